// File: hdl/sgl_pkg.sv
package sgl_pkg;

    // Sample format and counting limits
    localparam int FRAC_BITS      = 8;
    localparam int MAX_VECTOR_LEN = 65536;
    localparam int CNT_W          = 17;
    localparam logic [CNT_W-1:0] COUNT_CAP = (MAX_VECTOR_LEN < 131071) ?
        CNT_W'(MAX_VECTOR_LEN) : CNT_W'(131071);

    // Fixed-point constants of the exponential (Q24)
    localparam int XQ_SHIFT = 24 - FRAC_BITS;
    localparam logic signed [16:0] CLAMP_LIM = 17'sd22528;
    localparam logic signed [25:0] LOG2E_Q24 = 26'sd24204406;
    localparam logic signed [24:0] LN2_NET   = 25'sd11629080;
    localparam logic signed [22:0] SIXTH_Q24 = 23'sd2796203;
    localparam logic signed [26:0] HALF_Q24  = 27'sd8388608;
    localparam logic signed [26:0] ONE_Q24   = 27'sd16777216;
    localparam logic signed [7:0]  N_ZERO_LIM = 8'sd30;
    localparam logic [6:0]         N_UFLOW_LIM = 7'd40;

    // Divider sizing
    localparam int D_W    = 57;
    localparam int MAG_W  = 31 + XQ_SHIFT;
    localparam int QUOT_W = 23;
    localparam int ITER_W = 5;
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(QUOT_W - 1);

    // Queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    typedef struct packed {
        logic [D_W-1:0]   divisor;
        logic [MAG_W-1:0] mag;
        logic             neg;
        logic             zero;
        logic             last;
    } item_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

// File: hdl/sgl_queue.sv
module sgl_queue (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  sgl_pkg::item_t  push_item,
    input  logic            pop,
    output logic            not_empty,
    output sgl_pkg::item_t  head_item
);

    sgl_pkg::item_t                   mem_reg [sgl_pkg::QUEUE_DEPTH];
    logic [sgl_pkg::QPTR_W-1:0]       wr_ptr_reg;
    logic [sgl_pkg::QPTR_W-1:0]       rd_ptr_reg;
    logic [sgl_pkg::QCNT_W-1:0]       count_reg;

    function automatic logic [sgl_pkg::QCNT_W-1:0] QCNT_Wc(input logic b);
        return {{(sgl_pkg::QCNT_W-1){1'b0}}, b};
    endfunction

    assign not_empty = (count_reg != '0);
    assign head_item = mem_reg[rd_ptr_reg];

    // Store pushed entries
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + QCNT_Wc(push) - QCNT_Wc(pop);
        end
    end

endmodule

// File: hdl/sgl_front.sv
module sgl_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic signed [15:0]  s_gate_sample,
    input  logic signed [15:0]  s_value_sample,
    input  logic                s_end_of_vector,
    input  logic                pop,
    output logic                push,
    output sgl_pkg::item_t      push_item
);

    logic [sgl_pkg::QCNT_W-1:0] credit_reg;
    logic                       accept;

    // Stage registers
    logic        v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg;
    logic signed [31:0] xq1_reg, xq2_reg;
    logic signed [7:0]  n2_reg, n3_reg, n4_reg, n5_reg, n6_reg;
    logic signed [25:0] r3_reg, r4_reg, r5_reg;
    logic signed [26:0] p4_reg, p5_reg;
    logic [25:0]        p6_reg;
    logic               z3_reg, z4_reg, z5_reg, z6_reg, z7_reg;
    logic [30:0]        ab1_reg, ab2_reg, ab3_reg, ab4_reg, ab5_reg, ab6_reg, ab7_reg;
    logic               ng1_reg, ng2_reg, ng3_reg, ng4_reg, ng5_reg, ng6_reg, ng7_reg;
    logic               l1_reg, l2_reg, l3_reg, l4_reg, l5_reg, l6_reg, l7_reg;
    logic [sgl_pkg::D_W-1:0] d7_reg;

    // Stage logic
    logic signed [16:0] x_neg, x_clamp;
    logic signed [31:0] gv_prod;
    logic signed [57:0] t2;
    logic signed [32:0] nl3, r3;
    logic signed [48:0] m4;
    logic signed [52:0] m5, m6;
    logic signed [26:0] p6s;
    logic [6:0]         nneg7;
    logic [sgl_pkg::D_W-1:0] e7;

    // Keep the pipeline plus queue within the queue depth
    assign s_ready = (credit_reg < sgl_pkg::QCNT_W'(sgl_pkg::QUEUE_DEPTH));
    assign accept  = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_reg + {{(sgl_pkg::QCNT_W-1){1'b0}}, accept}
                                     - {{(sgl_pkg::QCNT_W-1){1'b0}}, pop};
        end
    end

    // Negate and clamp the gate, form gate times value
    always_comb begin
        x_neg = -17'(s_gate_sample);
        if (x_neg > sgl_pkg::CLAMP_LIM) begin
            x_clamp = sgl_pkg::CLAMP_LIM;
        end else if (x_neg < -sgl_pkg::CLAMP_LIM) begin
            x_clamp = -sgl_pkg::CLAMP_LIM;
        end else begin
            x_clamp = x_neg;
        end
        gv_prod = 32'(s_gate_sample) * 32'(s_value_sample);
    end

    // Range reduction and polynomial
    assign t2  = 58'(xq1_reg) * 58'(sgl_pkg::LOG2E_Q24);
    assign nl3 = 33'(n2_reg) * 33'(sgl_pkg::LN2_NET);
    assign r3  = 33'(xq2_reg) - nl3;
    assign m4  = 49'(sgl_pkg::SIXTH_Q24) * 49'(r3_reg);
    assign m5  = 53'(p4_reg) * 53'(r4_reg);
    assign m6  = 53'(p5_reg) * 53'(r5_reg);
    assign p6s = 27'(m6 >>> 24) + sgl_pkg::ONE_Q24;

    // Scale by two to the power n, form the divisor
    always_comb begin
        nneg7 = 7'(-n6_reg);
        if (!n6_reg[7]) begin
            e7 = sgl_pkg::D_W'(p6_reg) << n6_reg[6:0];
        end else if (nneg7 >= sgl_pkg::N_UFLOW_LIM) begin
            e7 = '0;
        end else begin
            e7 = sgl_pkg::D_W'(p6_reg) >> nneg7;
        end
    end

    // Advance valid flags
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
            v6_reg <= 1'b0;
            v7_reg <= 1'b0;
        end else begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
        end
    end

    // Advance payload
    always_ff @(posedge aclk) begin
        xq1_reg <= 32'(x_clamp) <<< sgl_pkg::XQ_SHIFT;
        ab1_reg <= gv_prod[31] ? 31'(-gv_prod) : gv_prod[30:0];
        ng1_reg <= gv_prod[31];
        l1_reg  <= s_end_of_vector;

        xq2_reg <= xq1_reg;
        n2_reg  <= t2[55:48];
        ab2_reg <= ab1_reg;
        ng2_reg <= ng1_reg;
        l2_reg  <= l1_reg;

        r3_reg  <= r3[25:0];
        n3_reg  <= n2_reg;
        z3_reg  <= (n2_reg > sgl_pkg::N_ZERO_LIM);
        ab3_reg <= ab2_reg;
        ng3_reg <= ng2_reg;
        l3_reg  <= l2_reg;

        p4_reg  <= 27'(m4 >>> 24) + sgl_pkg::HALF_Q24;
        r4_reg  <= r3_reg;
        n4_reg  <= n3_reg;
        z4_reg  <= z3_reg;
        ab4_reg <= ab3_reg;
        ng4_reg <= ng3_reg;
        l4_reg  <= l3_reg;

        p5_reg  <= 27'(m5 >>> 24) + sgl_pkg::ONE_Q24;
        r5_reg  <= r4_reg;
        n5_reg  <= n4_reg;
        z5_reg  <= z4_reg;
        ab5_reg <= ab4_reg;
        ng5_reg <= ng4_reg;
        l5_reg  <= l4_reg;

        p6_reg  <= p6s[26] ? '0 : p6s[25:0];
        n6_reg  <= n5_reg;
        z6_reg  <= z5_reg;
        ab6_reg <= ab5_reg;
        ng6_reg <= ng5_reg;
        l6_reg  <= l5_reg;

        d7_reg  <= sgl_pkg::D_W'(sgl_pkg::ONE_Q24) + e7;
        z7_reg  <= z6_reg;
        ab7_reg <= ab6_reg;
        ng7_reg <= ng6_reg;
        l7_reg  <= l6_reg;
    end

    // Hand the classified transaction to the queue
    assign push              = v7_reg;
    assign push_item.divisor = d7_reg;
    assign push_item.mag     = {ab7_reg, {sgl_pkg::XQ_SHIFT{1'b0}}};
    assign push_item.neg     = ng7_reg;
    assign push_item.zero    = z7_reg;
    assign push_item.last    = l7_reg;

endmodule

// File: hdl/sgl_back.sv
module sgl_back (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_not_empty,
    input  sgl_pkg::item_t                q_item,
    output logic                          pop,
    input  logic [22:0]                   threshold,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [23:0]            m_product,
    output logic                          m_kept,
    output logic                          m_end_of_vector_out,
    output logic [sgl_pkg::CNT_W-1:0]     m_nonzero_count
);

    sgl_pkg::back_state_t state_reg, state_next;
    logic                 load_out;

    logic [sgl_pkg::D_W-1:0]    div_reg;
    logic [sgl_pkg::D_W-1:0]    rem_reg;
    logic [sgl_pkg::QUOT_W-1:0] low_reg;
    logic [sgl_pkg::QUOT_W-1:0] quo_reg;
    logic [sgl_pkg::ITER_W-1:0] iter_reg;
    logic                       neg_reg;
    logic                       last_reg;
    logic [sgl_pkg::CNT_W-1:0]  cnt_reg;
    logic                       m_valid_reg;
    logic signed [23:0]         product_reg;
    logic                       kept_reg;
    logic                       eov_reg;
    logic [sgl_pkg::CNT_W-1:0]  count_out_reg;

    logic [sgl_pkg::D_W:0]      num_init;
    logic [sgl_pkg::D_W:0]      trial;
    logic                       ge;
    logic signed [23:0]         y_signed;
    logic                       keep;
    logic [sgl_pkg::CNT_W-1:0]  cnt_next;

    // Hold the state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sgl_pkg::BK_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Sequence take, divide and hand-off
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        load_out   = 1'b0;
        case (state_reg)
            sgl_pkg::BK_IDLE: begin
                if (q_not_empty) begin
                    pop        = 1'b1;
                    state_next = q_item.zero ? sgl_pkg::BK_DONE : sgl_pkg::BK_DIV;
                end
            end
            sgl_pkg::BK_DIV: begin
                if (iter_reg == sgl_pkg::LAST_ITER) begin
                    state_next = sgl_pkg::BK_DONE;
                end
            end
            sgl_pkg::BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    load_out   = 1'b1;
                    state_next = sgl_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = sgl_pkg::BK_IDLE;
            end
        endcase
    end

    // Rounded numerator and one restoring step
    assign num_init = (sgl_pkg::D_W+1)'(q_item.mag)
                    + (sgl_pkg::D_W+1)'(q_item.divisor >> 1);
    assign trial    = {rem_reg, low_reg[sgl_pkg::QUOT_W-1]};
    assign ge       = (trial >= {1'b0, div_reg});

    always_ff @(posedge aclk) begin
        if (pop) begin
            div_reg  <= q_item.divisor;
            rem_reg  <= sgl_pkg::D_W'(num_init >> sgl_pkg::QUOT_W);
            low_reg  <= num_init[sgl_pkg::QUOT_W-1:0];
            quo_reg  <= '0;
            iter_reg <= '0;
            neg_reg  <= q_item.neg;
            last_reg <= q_item.last;
        end else if (state_reg == sgl_pkg::BK_DIV) begin
            rem_reg  <= ge ? sgl_pkg::D_W'(trial - {1'b0, div_reg}) : trial[sgl_pkg::D_W-1:0];
            low_reg  <= {low_reg[sgl_pkg::QUOT_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[sgl_pkg::QUOT_W-2:0], ge};
            iter_reg <= iter_reg + 1'b1;
        end
    end

    // Apply sign, sparsity mask and kept count
    assign y_signed = neg_reg ? -{1'b0, quo_reg} : {1'b0, quo_reg};
    assign keep     = (threshold == '0) || (quo_reg >= threshold);
    assign cnt_next = (keep && (cnt_reg < sgl_pkg::COUNT_CAP)) ? cnt_reg + 1'b1 : cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (load_out) begin
                cnt_reg     <= last_reg ? '0 : cnt_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            product_reg   <= keep ? y_signed : '0;
            kept_reg      <= keep;
            eov_reg       <= last_reg;
            count_out_reg <= cnt_next;
        end
    end

    assign m_valid             = m_valid_reg;
    assign m_product           = product_reg;
    assign m_kept              = kept_reg;
    assign m_end_of_vector_out = eov_reg;
    assign m_nonzero_count     = count_out_reg;

endmodule

// File: hdl/swiglu_sparse_activation.sv
// SwiGLU with magnitude sparsity: each transaction carries a Q8.8 gate and
// value and yields value * gate / (1 + exp(-gate)) as Q16.8, zeroed when its
// magnitude is below the threshold register (0 keeps everything), with a running
// kept count that clears after the end-of-vector result. A seven-stage front
// computes the exponential and the divisor; a bit-serial divider in the back
// produces one quotient bit per cycle, so each transaction passes in the back
// through take, 23 divide steps and hand-off, or take and hand-off alone when
// the gate is so negative that the result is zero. The front runs up to eight
// transactions ahead through the queue; m_valid rises once an accepted input
// transaction has passed the front stages, the queue and the back. Write the
// threshold only while no transaction is in flight.
module swiglu_sparse_activation (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [22:0]                       cfg_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [15:0]                s_gate_sample,
    input  logic signed [15:0]                s_value_sample,
    input  logic                              s_end_of_vector,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [23:0]                m_product,
    output logic                              m_kept,
    output logic                              m_end_of_vector_out,
    output logic [sgl_pkg::CNT_W-1:0]         m_nonzero_count
);

    logic [22:0]    threshold_reg;
    logic           push, pop, q_not_empty;
    sgl_pkg::item_t push_item, head_item;

    // Hold the threshold register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            threshold_reg <= '0;
        end else if (cfg_valid) begin
            threshold_reg <= cfg_data;
        end
    end

    sgl_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_gate_sample   (s_gate_sample),
        .s_value_sample  (s_value_sample),
        .s_end_of_vector (s_end_of_vector),
        .pop             (pop),
        .push            (push),
        .push_item       (push_item)
    );

    sgl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .not_empty (q_not_empty),
        .head_item (head_item)
    );

    sgl_back u_back (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .q_not_empty         (q_not_empty),
        .q_item              (head_item),
        .pop                 (pop),
        .threshold           (threshold_reg),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_product           (m_product),
        .m_kept              (m_kept),
        .m_end_of_vector_out (m_end_of_vector_out),
        .m_nonzero_count     (m_nonzero_count)
    );

endmodule
